>>> rtl/core/sm3_pkg.sv
// Shared types, constants and bit functions for the SM3 hash engine.
// Depends on nothing; used by sm3_round and sm3_hash_engine.

package sm3_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } digest_t;

    // Eight 32-bit words; index 0 is register A (or chain word 0).
    typedef logic [7:0][31:0]  word8_t;
    // Sixteen-word message window; index 0 is W[j] during the rounds.
    typedef logic [15:0][31:0] word16_t;

    localparam logic [31:0] T_LOW      = 32'h79CC4519;
    // Round constant for round 16: the upper constant rotated left by 16.
    localparam logic [31:0] T_HIGH_ROT = 32'h9D8A7A87;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [6:0]  LEN_FILL   = 7'd56;
    localparam logic [6:0]  BLOCK_FILL = 7'd64;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [5:0]  HIGH_ROUND = 6'd15;

    localparam word8_t IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        p0 = x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        p1 = x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

>>> rtl/core/sm3_round.sv
// One SM3 compression round plus one message expansion step.
// Depends on sm3_pkg for the word types and the P0, P1 and rotate functions.

module sm3_round (
    input  sm3_pkg::word8_t  regs,
    input  sm3_pkg::word16_t win,
    input  logic [31:0]      tj,
    input  logic             high_half,
    output sm3_pkg::word8_t  regs_next,
    output logic [31:0]      w_new
);

    logic [31:0] a12;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] tt1;
    logic [31:0] tt2;

    always_comb
    begin
        a12 = sm3_pkg::rotl(regs[0], 12);
        ss1 = sm3_pkg::rotl(a12 + regs[4] + tj, 7);
        ss2 = ss1 ^ a12;
        if (high_half)
        begin
            ff = (regs[0] & regs[1]) | (regs[0] & regs[2]) | (regs[1] & regs[2]);
            gg = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
        end
        else
        begin
            ff = regs[0] ^ regs[1] ^ regs[2];
            gg = regs[4] ^ regs[5] ^ regs[6];
        end
        // W'[j] is W[j] ^ W[j+4], both taken from the sliding window.
        tt1 = ff + regs[3] + ss2 + (win[0] ^ win[4]);
        tt2 = gg + regs[7] + ss1 + win[0];

        regs_next[0] = tt1;
        regs_next[1] = regs[0];
        regs_next[2] = sm3_pkg::rotl(regs[1], 9);
        regs_next[3] = regs[2];
        regs_next[4] = sm3_pkg::p0(tt2);
        regs_next[5] = regs[4];
        regs_next[6] = sm3_pkg::rotl(regs[5], 19);
        regs_next[7] = regs[6];

        // W[j+16] from W[j], W[j+3], W[j+7], W[j+10] and W[j+13].
        w_new = sm3_pkg::p1(win[0] ^ win[7] ^ sm3_pkg::rotl(win[13], 15))
              ^ sm3_pkg::rotl(win[3], 7) ^ win[10];
    end

endmodule

>>> rtl/core/sm3_hash_engine.sv
// SM3 hash engine top level: byte packing, padding, round sequencer, digest out.
// Depends on sm3_pkg and sm3_round.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  message  | msg_valid / msg_ready        | msg    (data_word, byte_count, last)
//  digest   | digest_valid / digest_ready  | digest (digest_word, digest_last)
//
// An accepted transaction has its bytes (four at most) packed into the block in turn.
// Each full 64-byte block takes 64 rounds through the shared round unit and a fold.
// The last transaction adds padding, one or two block compressions and publishing of the digest.
// The digest moves to an eight-word output buffer, which drains while new input is taken.
// msg_ready is low while a transaction is in work; reset returns to the SM3 initial value.

module sm3_hash_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             msg_valid,
    output logic             msg_ready,
    input  sm3_pkg::msg_t    msg,
    output logic             digest_valid,
    input  logic             digest_ready,
    output sm3_pkg::digest_t digest
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    sm3_pkg::word8_t  cv_reg, cv_next;
    sm3_pkg::word8_t  wr_reg, wr_next;
    sm3_pkg::word16_t win_reg, win_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic [31:0]      tj_reg, tj_next;
    logic [6:0]       fill_reg, fill_next;
    logic [63:0]      bits_reg, bits_next;
    logic [31:0]      word_reg, word_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             final_reg, final_next;
    logic             resume_pad_reg, resume_pad_next;
    sm3_pkg::word8_t  dig_reg, dig_next;
    logic [2:0]       dig_idx_reg, dig_idx_next;
    logic             dig_valid_reg, dig_valid_next;

    sm3_pkg::word8_t  round_regs;
    logic [31:0]      round_w;
    logic [2:0]       in_count;
    logic [7:0]       put_val;
    logic [6:0]       fill_inc;
    logic [3:0]       put_word;
    logic [1:0]       put_pos;

    sm3_round u_round (
        .regs      (wr_reg),
        .win       (win_reg),
        .tj        (tj_reg),
        .high_half (rnd_reg[5:4] != 2'b00),
        .regs_next (round_regs),
        .w_new     (round_w)
    );

    assign msg_ready    = (state_reg == ST_IDLE);
    assign digest_valid = dig_valid_reg;
    assign digest.digest_word = dig_reg[0];
    assign digest.digest_last = (dig_idx_reg == 3'd7);

    always_comb
    begin
        state_next      = state_reg;
        cv_next         = cv_reg;
        wr_next         = wr_reg;
        win_next        = win_reg;
        rnd_next        = rnd_reg;
        tj_next         = tj_reg;
        fill_next       = fill_reg;
        bits_next       = bits_reg;
        word_next       = word_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        final_next      = final_reg;
        resume_pad_next = resume_pad_reg;
        dig_next        = dig_reg;
        dig_idx_next    = dig_idx_reg;
        dig_valid_next  = dig_valid_reg;

        in_count = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
        put_val  = (cnt_reg != 3'd0) ? word_reg[31:24] : sm3_pkg::PAD_BYTE;
        put_word = fill_reg[5:2];
        put_pos  = fill_reg[1:0];
        fill_inc = fill_reg + 7'd1;

        if (dig_valid_reg && digest_ready)
        begin
            for (int i = 0; i < 7; i++)
            begin
                dig_next[i] = dig_reg[i + 1];
            end
            dig_idx_next = dig_idx_reg + 3'd1;
            if (dig_idx_reg == 3'd7)
            begin
                dig_valid_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    cnt_next   = in_count;
                    last_next  = msg.last;
                    unique case (in_count)
                        3'd0:    word_next = 32'h0;
                        3'd1:    word_next = {msg.data_word[31:24], 24'h0};
                        3'd2:    word_next = {msg.data_word[31:16], 16'h0};
                        3'd3:    word_next = {msg.data_word[31:8], 8'h0};
                        default: word_next = msg.data_word;
                    endcase
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (cnt_reg != 3'd0 || last_reg)
                begin
                    // The first byte of a word clears the rest of it, so unfilled
                    // positions always read as zero.
                    if (put_pos == 2'd0)
                    begin
                        win_next[put_word] = {put_val, 24'h0};
                    end
                    else
                    begin
                        win_next[put_word][(2'd3 - put_pos) * 8 +: 8] = put_val;
                    end
                end
                if (cnt_reg != 3'd0)
                begin
                    cnt_next  = cnt_reg - 3'd1;
                    word_next = {word_reg[23:0], 8'h0};
                    bits_next = bits_reg + 64'd8;
                    fill_next = fill_inc;
                    if (fill_inc == sm3_pkg::BLOCK_FILL)
                    begin
                        fill_next       = 7'd0;
                        final_next      = 1'b0;
                        resume_pad_next = 1'b0;
                        wr_next         = cv_reg;
                        rnd_next        = 6'd0;
                        tj_next         = sm3_pkg::T_LOW;
                        state_next      = ST_ROUND;
                    end
                end
                else if (last_reg)
                begin
                    // Skip to the next word boundary after the pad byte.
                    fill_next  = {1'b0, fill_reg[5:2], 2'b00} + 7'd4;
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PAD:
            begin
                if (fill_reg == sm3_pkg::LEN_FILL)
                begin
                    win_next[14] = bits_reg[63:32];
                    win_next[15] = bits_reg[31:0];
                    final_next   = 1'b1;
                    wr_next      = cv_reg;
                    rnd_next     = 6'd0;
                    tj_next      = sm3_pkg::T_LOW;
                    state_next   = ST_ROUND;
                end
                else if (fill_reg == sm3_pkg::BLOCK_FILL)
                begin
                    fill_next       = 7'd0;
                    final_next      = 1'b0;
                    resume_pad_next = 1'b1;
                    wr_next         = cv_reg;
                    rnd_next        = 6'd0;
                    tj_next         = sm3_pkg::T_LOW;
                    state_next      = ST_ROUND;
                end
                else
                begin
                    win_next[fill_reg[5:2]] = 32'h0;
                    fill_next = fill_reg + 7'd4;
                end
            end

            ST_ROUND:
            begin
                wr_next = round_regs;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = round_w;
                tj_next  = (rnd_reg == sm3_pkg::HIGH_ROUND) ? sm3_pkg::T_HIGH_ROT
                                                            : sm3_pkg::rotl(tj_reg, 1);
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == sm3_pkg::LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                cv_next  = cv_reg ^ wr_reg;
                rnd_next = 6'd0;
                tj_next  = sm3_pkg::T_LOW;
                if (final_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (resume_pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end

            ST_DONE:
            begin
                // Wait until the previous digest has fully drained.
                if (!dig_valid_reg)
                begin
                    dig_next       = cv_reg;
                    dig_idx_next   = 3'd0;
                    dig_valid_next = 1'b1;
                    cv_next        = sm3_pkg::IV;
                    bits_next      = 64'd0;
                    fill_next      = 7'd0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cv_reg         <= sm3_pkg::IV;
            wr_reg         <= '0;
            rnd_reg        <= 6'd0;
            tj_reg         <= sm3_pkg::T_LOW;
            fill_reg       <= 7'd0;
            bits_reg       <= 64'd0;
            word_reg       <= 32'h0;
            cnt_reg        <= 3'd0;
            last_reg       <= 1'b0;
            final_reg      <= 1'b0;
            resume_pad_reg <= 1'b0;
            dig_idx_reg    <= 3'd0;
            dig_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cv_reg         <= cv_next;
            wr_reg         <= wr_next;
            rnd_reg        <= rnd_next;
            tj_reg         <= tj_next;
            fill_reg       <= fill_next;
            bits_reg       <= bits_next;
            word_reg       <= word_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            final_reg      <= final_next;
            resume_pad_reg <= resume_pad_next;
            dig_idx_reg    <= dig_idx_next;
            dig_valid_reg  <= dig_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        dig_reg <= dig_next;
    end

`ifndef SYNTHESIS
    a_round_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg != sm3_pkg::LAST_ROUND) |=> state_reg == ST_ROUND)
        else $error("compression left the round loop early");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[6] |-> (fill_reg[5:0] == 6'd0))
        else $error("block fill count beyond one block");

    a_pad_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (fill_reg[1:0] == 2'd0))
        else $error("padding started off a word boundary");

    a_done_publish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !dig_valid_reg) |=> (dig_valid_reg && dig_idx_reg == 3'd0))
        else $error("digest not published after final fold");
`endif

endmodule
